>>> design/iee_pkg.sv
// Package for the infix expression evaluator: character codes, operator
// codes, status codes and default stack depths. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package iee_pkg;
  localparam int OperandDepthDef  = 16;
  localparam int OperatorDepthDef = 16;

  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChStar  = 8'h2A;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChNl    = 8'h0A;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DIV0  = 2'd1,
    ST_UNDER = 2'd2,
    ST_OVER  = 2'd3
  } status_t;
endpackage
`default_nettype wire

>>> design/infix_expression_evaluator.sv
// Infix expression evaluator top level: sequencer, stack memories, shared
// serial divider. Depends on iee_pkg.
`timescale 1ns / 1ps
`default_nettype none
// Takes one ASCII character per transaction on the in_ channel. Digits build a
// 32-bit number, + - * / are stacked with precedence and reduced left to
// right; newline or in_tlast finishes the expression and one transaction
// carrying {status, value} leaves on out_. Both stacks live in synchronous
// memories with registered reads. A digit or ignored character is accepted
// and decoded. An operator is accepted, decoded, the top operator is read,
// and the two are compared. Each reduction reads two operands, runs the ALU,
// writes back and reads the top operator afresh. A division also runs the
// radix-2 unit, which retires one quotient bit a cycle. A finish walks the
// same reduce loop without the push, then reads the bottom operand and holds
// the result until out_tready; a digit carrying the finish passes through
// decode a second time. Errors are sticky until the end of the expression;
// the result value is then 0. After reset the block is ready at once; the
// memories need no clearing.
module infix_expression_evaluator
  import iee_pkg::*;
#(
  parameter int OPERAND_DEPTH  = OperandDepthDef,
  parameter int OPERATOR_DEPTH = OperatorDepthDef
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] character
  input  wire logic        in_tlast,   // end_of_expression
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata   // [31:0] value, [33:32] status, rest 0
);
  localparam int AW = (OPERAND_DEPTH  > 1) ? $clog2(OPERAND_DEPTH)  : 1;
  localparam int PW = (OPERATOR_DEPTH > 1) ? $clog2(OPERATOR_DEPTH) : 1;
  localparam int CW = $clog2(OPERAND_DEPTH + 1);
  localparam int KW = $clog2(OPERATOR_DEPTH + 1);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_DEC   = 12'b000000000010, // decode character, flush number
    S_PEEK  = 12'b000000000100, // read top operator
    S_CMP   = 12'b000000001000, // decide reduce or push
    S_RRHS  = 12'b000000010000,
    S_RLHS  = 12'b000000100000,
    S_ALU   = 12'b000001000000,
    S_DIV   = 12'b000010000000,
    S_WB    = 12'b000100000000,
    S_FIN   = 12'b001000000000, // read bottom operand
    S_FIN2  = 12'b010000000000,
    S_OUT   = 12'b100000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [31:0] opnd_mem [OPERAND_DEPTH];
  logic [1:0]  oper_mem [OPERATOR_DEPTH];
  logic [31:0] opnd_rd_r;
  logic [1:0]  oper_rd_r;

  logic [CW-1:0] ocnt_r, ocnt_nxt;
  logic [KW-1:0] kcnt_r, kcnt_nxt;
  logic [31:0]   acc_r, acc_nxt;
  logic          innum_r, innum_nxt;
  logic [1:0]    err_r, err_nxt;
  logic [7:0]    ch_r, ch_nxt;
  logic          fin_r, fin_nxt;
  logic [31:0]   rhs_r, rhs_nxt, lhs_r, lhs_nxt, res_r, res_nxt;
  logic [1:0]    op_r, op_nxt;
  // divider
  logic [31:0]   dq_r, dq_nxt, dd_r, dd_nxt;
  logic [32:0]   drem_r, drem_nxt;
  logic [5:0]    dcnt_r, dcnt_nxt;
  logic          dneg_r, dneg_nxt;
  logic [31:0]   out_val_r, out_val_nxt;
  logic [1:0]    out_st_r, out_st_nxt;

  // memory ports
  logic          opnd_we, oper_we;
  logic [AW-1:0] opnd_wa, opnd_ra;
  logic [PW-1:0] oper_wa, oper_ra;
  logic [31:0]   opnd_wd;
  logic [1:0]    oper_wd;

  always_ff @(posedge clk) begin
    if (opnd_we) opnd_mem[opnd_wa] <= opnd_wd;
    if (oper_we) oper_mem[oper_wa] <= oper_wd;
    opnd_rd_r <= opnd_mem[opnd_ra];
    oper_rd_r <= oper_mem[oper_ra];
  end

  logic is_digit, is_op;
  logic [1:0] ch_code;
  logic [32:0] dtrial;
  logic [31:0] mag_l, mag_r;

  always_comb begin
    is_digit = (ch_r >= ChZero) && (ch_r <= ChNine);
    is_op    = 1'b1;
    ch_code  = OP_ADD;
    unique case (ch_r)
      ChPlus:  ch_code = OP_ADD;
      ChMinus: ch_code = OP_SUB;
      ChStar:  ch_code = OP_MUL;
      ChSlash: ch_code = OP_DIV;
      default: is_op = 1'b0;
    endcase
    mag_l  = lhs_r[31] ? (32'd0 - lhs_r) : lhs_r;
    mag_r  = rhs_r[31] ? (32'd0 - rhs_r) : rhs_r;
    dtrial = {drem_r[31:0], dq_r[31]} - {1'b0, dd_r};
  end

  always_comb begin
    state_nxt = state_r;
    ocnt_nxt = ocnt_r; kcnt_nxt = kcnt_r; acc_nxt = acc_r; innum_nxt = innum_r;
    err_nxt = err_r; ch_nxt = ch_r; fin_nxt = fin_r;
    rhs_nxt = rhs_r; lhs_nxt = lhs_r; res_nxt = res_r; op_nxt = op_r;
    dq_nxt = dq_r; dd_nxt = dd_r; drem_nxt = drem_r; dcnt_nxt = dcnt_r;
    dneg_nxt = dneg_r; out_val_nxt = out_val_r; out_st_nxt = out_st_r;
    opnd_we = 1'b0; oper_we = 1'b0;
    opnd_wa = ocnt_r[AW-1:0]; opnd_wd = acc_r;
    opnd_ra = '0;
    oper_wa = kcnt_r[PW-1:0]; oper_wd = ch_code;
    oper_ra = '0;
    in_tready = (state_r == S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          ch_nxt    = in_tdata;
          fin_nxt   = in_tlast || (in_tdata == ChNl);
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (err_r == ST_OK && is_digit) begin
          acc_nxt   = 32'(acc_r * 32'd10) + {24'd0, ch_r - ChZero};
          innum_nxt = 1'b1;
          state_nxt = fin_r ? S_DEC : S_IDLE;
          ch_nxt    = fin_r ? 8'd0 : ch_r;
          if (!fin_r) state_nxt = S_IDLE;
        end else if (err_r == ST_OK && (is_op || fin_r)) begin
          if (innum_r) begin
            if (ocnt_r >= CW'(OPERAND_DEPTH)) err_nxt = ST_OVER;
            else begin
              opnd_we  = 1'b1;
              ocnt_nxt = ocnt_r + 1'b1;
            end
            acc_nxt = '0; innum_nxt = 1'b0;
          end
          if (!is_op) ch_nxt = 8'd0; // finish path
          state_nxt = S_PEEK;
        end else begin
          state_nxt = fin_r ? S_FIN : S_IDLE;
        end
      end
      S_PEEK: begin
        oper_ra   = PW'(kcnt_r - 1'b1);
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (err_r != ST_OK) state_nxt = fin_r ? S_FIN : S_IDLE;
        else if (kcnt_r != '0 && (!is_op || ch_code[1] <= oper_rd_r[1])) begin
          op_nxt = oper_rd_r;
          if (ocnt_r < CW'(2)) begin
            err_nxt = ST_UNDER;
            state_nxt = fin_r ? S_FIN : S_IDLE;
          end else begin
            opnd_ra   = AW'(ocnt_r - 1'b1);
            kcnt_nxt  = kcnt_r - 1'b1;
            state_nxt = S_RRHS;
          end
        end else if (is_op) begin
          if (kcnt_r >= KW'(OPERATOR_DEPTH)) err_nxt = ST_OVER;
          else begin
            oper_we  = 1'b1;
            kcnt_nxt = kcnt_r + 1'b1;
          end
          state_nxt = fin_r ? S_DEC : S_IDLE;
          if (fin_r) ch_nxt = 8'd0;
          if (fin_r) state_nxt = S_PEEK;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_RRHS: begin
        rhs_nxt   = opnd_rd_r;
        opnd_ra   = AW'(ocnt_r - CW'(2));
        state_nxt = S_RLHS;
      end
      S_RLHS: begin
        lhs_nxt   = opnd_rd_r;
        ocnt_nxt  = ocnt_r - CW'(2);
        state_nxt = S_ALU;
      end
      S_ALU: begin
        unique case (op_r)
          OP_ADD: begin res_nxt = lhs_r + rhs_r; state_nxt = S_WB; end
          OP_SUB: begin res_nxt = lhs_r - rhs_r; state_nxt = S_WB; end
          OP_MUL: begin res_nxt = 32'(lhs_r * rhs_r); state_nxt = S_WB; end
          default: begin
            if (rhs_r == '0) begin
              err_nxt   = ST_DIV0;
              state_nxt = fin_r ? S_FIN : S_IDLE;
            end else begin
              dq_nxt    = mag_l;
              dd_nxt    = mag_r;
              drem_nxt  = '0;
              dcnt_nxt  = 6'd32;
              dneg_nxt  = lhs_r[31] ^ rhs_r[31];
              state_nxt = S_DIV;
            end
          end
        endcase
      end
      S_DIV: begin
        if (dcnt_r == '0) begin
          res_nxt   = dneg_r ? (32'd0 - dq_r) : dq_r;
          state_nxt = S_WB;
        end else begin
          if (!dtrial[32]) begin
            drem_nxt = dtrial;
            dq_nxt   = {dq_r[30:0], 1'b1};
          end else begin
            drem_nxt = {drem_r[31:0], dq_r[31]};
            dq_nxt   = {dq_r[30:0], 1'b0};
          end
          dcnt_nxt = dcnt_r - 1'b1;
        end
      end
      S_WB: begin
        opnd_we   = 1'b1;
        opnd_wd   = res_r;
        ocnt_nxt  = ocnt_r + 1'b1;
        state_nxt = S_PEEK;
      end
      S_FIN: begin
        opnd_ra   = '0;
        state_nxt = S_FIN2;
      end
      S_FIN2: begin
        if (err_r == ST_OK && ocnt_r != CW'(1)) begin
          out_st_nxt = ST_UNDER; out_val_nxt = '0;
        end else begin
          out_st_nxt  = err_r;
          out_val_nxt = (err_r == ST_OK) ? opnd_rd_r : '0;
        end
        ocnt_nxt = '0; kcnt_nxt = '0; acc_nxt = '0; innum_nxt = 1'b0;
        err_nxt = ST_OK; fin_nxt = 1'b0;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_tready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // finishing on a digit: after the digit is taken, rerun decode as a bare
  // finish (ch cleared), which flushes the number and reduces everything.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ocnt_r <= '0; kcnt_r <= '0; acc_r <= '0; innum_r <= 1'b0;
      err_r <= ST_OK; fin_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ocnt_r <= ocnt_nxt; kcnt_r <= kcnt_nxt; acc_r <= acc_nxt;
      innum_r <= innum_nxt; err_r <= err_nxt; fin_r <= fin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ch_r <= ch_nxt; rhs_r <= rhs_nxt; lhs_r <= lhs_nxt; res_r <= res_nxt;
    op_r <= op_nxt; dq_r <= dq_nxt; dd_r <= dd_nxt; drem_r <= drem_nxt;
    dcnt_r <= dcnt_nxt; dneg_r <= dneg_nxt;
    out_val_r <= out_val_nxt; out_st_r <= out_st_nxt;
  end

  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = {6'd0, out_st_r, out_val_r};
endmodule
`default_nettype wire

>>> design/iee_checker.sv
// Port-level checker for the infix expression evaluator, with its bind.
// Depends on nothing but the top level's ports.
`timescale 1ns / 1ps
`default_nettype none
module iee_port_props (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        in_tlast,
  input wire logic [7:0]  in_tdata,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [39:0] out_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[39:34] == 6'd0)
    else $error("pad bits set");
  a_err0: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[33:32] != 2'd0 |-> out_tdata[31:0] == 32'd0)
    else $error("nonzero value on error");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input taken while result pending");
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result after reset");
endmodule

bind infix_expression_evaluator iee_port_props u_iee_checker (.*);
`default_nettype wire

>>> tb/iee_checker.sv
// Checker for the infix expression evaluator: watches both stream channels,
// predicts each expression result and compares it. Depends on iee_pkg.
`timescale 1ns / 1ps
module iee_checker
  import iee_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,
  output int          fail_count,
  output int          pending
);
  localparam int NumDepth = OperandDepthDef;
  localparam int OpDepth  = OperatorDepthDef;

  typedef struct packed {
    logic [31:0] value;
    status_t     status;
  } expr_result_t;

  logic [31:0]   num_stk [NumDepth];
  op_t           op_stk  [OpDepth];
  int            num_cnt, op_cnt;
  logic [31:0]   acc;
  logic          in_num;
  status_t       err;
  expr_result_t  results_q[$];

  function automatic logic [31:0] div_trunc(logic [31:0] n, logic [31:0] d);
    logic [31:0] mn, md, q;
    mn = n[31] ? -n : n;
    md = d[31] ? -d : d;
    q  = mn / md;
    return (n[31] != d[31]) ? -q : q;
  endfunction

  task automatic flag(status_t s);
    if (err == ST_OK) err = s;
  endtask

  task automatic push_num(logic [31:0] v);
    if (err != ST_OK) return;
    if (num_cnt >= NumDepth) flag(ST_OVER);
    else begin
      num_stk[num_cnt] = v;
      num_cnt++;
    end
  endtask

  task automatic reduce();
    logic [31:0] a, b, r;
    op_t op;
    if (err != ST_OK || op_cnt == 0) return;
    if (num_cnt < 2) begin
      flag(ST_UNDER);
      return;
    end
    b = num_stk[num_cnt-1];
    a = num_stk[num_cnt-2];
    num_cnt -= 2;
    op_cnt--;
    op = op_stk[op_cnt];
    case (op)
      OP_ADD: r = a + b;
      OP_SUB: r = a - b;
      OP_MUL: r = a * b;
      default: begin
        if (b == 0) begin
          flag(ST_DIV0);
          return;
        end
        r = div_trunc(a, b);
      end
    endcase
    push_num(r);
  endtask

  task automatic flush_num();
    if (in_num) begin
      push_num(acc);
      acc = 0;
      in_num = 0;
    end
  endtask

  task automatic clear_state();
    num_cnt = 0;
    op_cnt  = 0;
    acc     = 0;
    in_num  = 0;
    err     = ST_OK;
  endtask

  // one accepted character; may queue one expected result
  task automatic eval_char(logic [7:0] ch, logic last);
    logic fin, is_op;
    op_t code;
    expr_result_t res;
    fin = last;
    is_op = 1;
    code = OP_ADD;
    case (ch)
      ChNl:    begin fin = 1; is_op = 0; end
      ChPlus:  code = OP_ADD;
      ChMinus: code = OP_SUB;
      ChStar:  code = OP_MUL;
      ChSlash: code = OP_DIV;
      default: is_op = 0;
    endcase
    if (err == ST_OK) begin
      if (ch >= ChZero && ch <= ChNine) begin
        acc = acc * 10 + 32'(ch - ChZero);
        in_num = 1;
      end else if (is_op) begin
        flush_num();
        while (err == ST_OK && op_cnt > 0 && code[1] <= op_stk[op_cnt-1][1])
          reduce();
        if (err == ST_OK) begin
          if (op_cnt >= OpDepth) flag(ST_OVER);
          else begin
            op_stk[op_cnt] = code;
            op_cnt++;
          end
        end
      end
    end
    if (!fin) return;
    flush_num();
    while (err == ST_OK && op_cnt > 0) reduce();
    if (err == ST_OK && num_cnt != 1) flag(ST_UNDER);
    res.value  = (err == ST_OK) ? num_stk[0] : 32'd0;
    res.status = err;
    results_q.push_back(res);
    clear_state();
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
    clear_state();
  end

  always @(posedge clk) begin
    expr_result_t exp_r;
    if (rst_n) begin
      // result first: a finishing character's result cannot leave the same edge
      if (out_tvalid && out_tready) begin
        if (results_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result value=%h status=%0d", $time,
                   out_tdata[31:0], out_tdata[33:32]);
        end else begin
          exp_r = results_q.pop_front();
          if (out_tdata[31:0] !== exp_r.value) begin
            fail_count++;
            $display("%0t: value expected %h actual %h", $time, exp_r.value,
                     out_tdata[31:0]);
          end
          if (out_tdata[33:32] !== exp_r.status) begin
            fail_count++;
            $display("%0t: status expected %0d actual %0d", $time, exp_r.status,
                     out_tdata[33:32]);
          end
          if (out_tdata[39:34] !== 6'd0) begin
            fail_count++;
            $display("%0t: padding expected 0 actual %h", $time, out_tdata[39:34]);
          end
        end
      end
      if (in_tvalid && in_tready) eval_char(in_tdata, in_tlast);
    end
    pending = results_q.size();
  end
endmodule

>>> tb/tb.sv
// Testbench top for the infix expression evaluator: clock, reset, character
// stimulus, idling phases and verdict. Depends on iee_pkg and iee_checker.
`timescale 1ns / 1ps
module tb;
  import iee_pkg::*;

  localparam int CycleLimit = 2_000_000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;    // [7:0] character
  logic        in_tlast;    // end_of_expression
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;   // [31:0] value, [33:32] status, rest 0
  int          fail_count;
  int          pending;
  int          cycles;

  // idle percentages, changed per phase by the stimulus process
  int          send_idle_pct;
  int          recv_stall_pct;
  logic        hold_off;    // long receiver hold-off request

  infix_expression_evaluator u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  iee_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // timeout watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= CycleLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // receiver: random stall, or a long counted hold-off when requested
  initial begin
    int n;
    out_tready = 0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_tready <= 0;
        for (n = 0; n < 400; n++) @(negedge clk);
        hold_off = 0;
      end
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // drive one character transaction; idles at random before offering
  task automatic send_char(logic [7:0] ch, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 0;
      @(negedge clk);
    end
    in_tvalid <= 1;
    in_tdata  <= ch;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_str(string s, logic last_flag);
    for (int i = 0; i < s.len(); i++)
      send_char(s[i], last_flag && (i == s.len() - 1));
  endtask

  function automatic logic [7:0] rand_op();
    case ($urandom_range(3))
      0: return ChPlus;
      1: return ChMinus;
      2: return ChStar;
      default: return ChSlash;
    endcase
  endfunction

  // mostly well-formed expressions with random numbers; some noise and breakage
  task automatic send_expr(output int sent);
    int terms, digits;
    logic [7:0] c;
    sent = 0;
    terms = ($urandom_range(19) == 0) ? $urandom_range(17, 20) : $urandom_range(1, 6);
    for (int t = 0; t < terms; t++) begin
      if (t > 0) begin
        send_char(rand_op(), 0);
        sent++;
        if ($urandom_range(29) == 0) begin
          send_char(rand_op(), 0);
          sent++;
        end
      end
      digits = ($urandom_range(9) == 0) ? $urandom_range(8, 12) : $urandom_range(1, 3);
      for (int d = 0; d < digits; d++) begin
        // small divisors, zeros included, show up often
        c = ChZero + 8'($urandom_range(9));
        send_char(c, 0);
        sent++;
        if ($urandom_range(24) == 0) begin
          send_char(8'($urandom_range(255)), 0);
          sent++;
        end
      end
    end
    if ($urandom_range(9) == 0) begin
      send_char(rand_op(), 0);
      sent++;
    end
    // terminate by newline, flag, flag on newline, or flag on last digit
    case ($urandom_range(3))
      0: send_char(ChNl, 0);
      1: send_char(8'h20, 1);
      2: send_char(ChNl, 1);
      default: send_char(ChZero + 8'($urandom_range(9)), 1);
    endcase
    sent++;
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  initial begin
    int count, sent;
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = 0;
    in_tlast = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off = 0;
    repeat (10) @(negedge clk);
    rst_n = 1;

    // directed: extremes, every operator, divide-by-zero and underflow cases
    send_str("4294967295+1\n", 0);         // wrap to 0
    send_str("2147483648/4294967295", 1);  // most negative / -1
    send_str("7-9*3/2+8", 1);              // precedence, left association
    send_str("0-7/2\n", 0);                // truncation toward zero
    send_str("5/0\n", 0);                  // divide by zero
    send_str("+3\n", 0);                   // operand underflow
    send_str("\n", 0);                     // empty expression
    send_str("1 2a\x7f+\xff3\n", 1);       // ignored chars, newline with flag
    send_str("1+2+3+4+5+6+7+8+9+1+2+3+4+5+6+7+8\n", 0);
    send_str("1*2*3*4*5*6*7*8*9*1*2*3*4*5*6*7*8\n", 0);
    send_str("1+2*3+4*5+6*7+8*9+1*2+3*4+5*6+7*8+9*1+2\n", 0);
    drain();

    // random phases: none, sender idle, receiver stall, both
    count = 0;
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1) ? 60 : (ph == 3) ? 18 : 0;
      recv_stall_pct = (ph == 2) ? 60 : (ph == 3) ? 18 : 0;
      while (count < (ph + 1) * 320) begin
        if (ph == 0 && count > 200 && !hold_off && cycles % 1000 < 5) hold_off = 1;
        send_expr(sent);
        count += sent;
      end
      // sender pause until every expected result is back
      drain();
    end
    hold_off = 1;
    repeat (20) begin
      send_expr(sent);
    end
    drain();

    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule

>>> sim.f
design/iee_pkg.sv
design/infix_expression_evaluator.sv
design/iee_checker.sv
tb/iee_checker.sv
tb/tb.sv
